// ----- design/bscfs_pkg.sv -----
// ----------------------------------------------------------------------------
// bscfs_pkg: shared types and constants of the byte stream CAN frame segmenter
// Ring geometry, frame layout constants, command and result types.
// ----------------------------------------------------------------------------
package bscfs_pkg;

   // Transmit ring geometry.
   localparam int RING_DEPTH = 127;
   localparam int PTR_W      = $clog2(RING_DEPTH);
   localparam int COUNT_W    = $clog2(RING_DEPTH + 1);

   // Frame layout: one header byte plus up to seven payload bytes.
   localparam int PAYLOAD_MAX = 7;
   localparam int CHUNK_W     = $clog2(PAYLOAD_MAX + 1);
   localparam int PIDX_W      = $clog2(PAYLOAD_MAX);
   localparam int MAX_FRAMES  = (RING_DEPTH + PAYLOAD_MAX - 1) / PAYLOAD_MAX;
   localparam int SEQ_W       = $clog2(MAX_FRAMES);
   localparam int LEN_W       = 4;
   localparam logic [7:0] FIRST_MARK = 8'h80;

   // Identifier and configuration.
   localparam int ID_W       = 29;
   localparam int SENDIDX_W  = 16;
   localparam int CSR_DATA_W = 29;
   localparam logic CSR_ID_BASE    = 1'b0;
   localparam logic CSR_SEND_INDEX = 1'b1;

   // Input opcodes.
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   // Command queue between front and back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Stream widths.
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_FIELDS_W = 1 + ID_W + LEN_W + 8 + 8 * PAYLOAD_MAX;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W    = RSP_TDATA_W - RSP_FIELDS_W;

   typedef enum logic {
      CMD_WRITE,
      CMD_FLUSH
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   data;
   } cmd_type;

   typedef struct packed {
      logic [PAYLOAD_MAX-1:0][7:0] pay;
      logic [7:0]                  byte0;
      logic [LEN_W-1:0]            frame_len;
      logic [ID_W-1:0]             frame_id;
      logic                        write_accepted;
      logic                        last;
   } rsp_type;

endpackage

// ----- design/bscfs_front.sv -----
// ----------------------------------------------------------------------------
// bscfs_front: request intake and command queue
// Accepts request transactions, decodes the opcode into a command kind and
// holds commands in a short queue until the back end takes them.
// ----------------------------------------------------------------------------
module bscfs_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_data,
   input  logic              req_opcode,
   output logic              cmd_valid,
   output bscfs_pkg::cmd_type cmd,
   input  logic              cmd_pop
);

   bscfs_pkg::cmd_type               entry_ff [bscfs_pkg::QUEUE_DEPTH];
   logic [bscfs_pkg::QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [bscfs_pkg::QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [bscfs_pkg::QCNT_W-1:0]     count_ff, count_in;
   bscfs_pkg::cmd_type               new_cmd;
   logic                             push;

   assign req_tready = (count_ff != bscfs_pkg::QCNT_W'(bscfs_pkg::QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign cmd_valid  = (count_ff != '0);
   assign cmd        = entry_ff[rd_ptr_ff];

   always_comb begin
      new_cmd.kind = (req_opcode == bscfs_pkg::OP_FLUSH) ? bscfs_pkg::CMD_FLUSH
                                                         : bscfs_pkg::CMD_WRITE;
      new_cmd.data = req_data;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == bscfs_pkg::QPTR_W'(bscfs_pkg::QUEUE_DEPTH - 1))
                     ? '0 : wr_ptr_ff + 1'b1;
      end
      if (cmd_pop) begin
         rd_ptr_in = (rd_ptr_ff == bscfs_pkg::QPTR_W'(bscfs_pkg::QUEUE_DEPTH - 1))
                     ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !cmd_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && cmd_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

// ----- design/bscfs_back.sv -----
// ----------------------------------------------------------------------------
// bscfs_back: transmit ring and frame sequencer
// Executes queued commands: stores bytes in the ring and answers each write,
// or drains the ring byte by byte into frames held in the output register.
// ----------------------------------------------------------------------------
module bscfs_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_valid,
   input  bscfs_pkg::cmd_type            cmd,
   output logic                          cmd_pop,
   input  logic [bscfs_pkg::ID_W-1:0]    frame_id,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output bscfs_pkg::rsp_type            rsp
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SEND
   } state_type;

   state_type                         state_ff, state_in;
   logic [bscfs_pkg::PTR_W-1:0]       wp_ff, wp_in;
   logic [bscfs_pkg::PTR_W-1:0]       rp_ff, rp_in;
   logic [bscfs_pkg::COUNT_W-1:0]     fill_ff, fill_in;
   logic [bscfs_pkg::COUNT_W-1:0]     total_ff, total_in;
   logic [bscfs_pkg::COUNT_W-1:0]     left_ff, left_in;
   logic [bscfs_pkg::SEQ_W-1:0]       seq_ff, seq_in;
   logic [bscfs_pkg::CHUNK_W-1:0]     issue_ff, issue_in;
   logic                              pend_ff, pend_in;
   logic [bscfs_pkg::PIDX_W-1:0]      pend_idx_ff, pend_idx_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   bscfs_pkg::rsp_type                rsp_ff, rsp_in;

   logic [7:0]                        ring_ff [bscfs_pkg::RING_DEPTH];
   logic [7:0]                        mem_q_ff;
   logic [7:0]                        payload_ff [bscfs_pkg::PAYLOAD_MAX];

   logic                              out_free;
   logic [bscfs_pkg::CHUNK_W-1:0]     chunk;
   logic                              wr_en;
   logic                              rd_en;
   logic                              cap_en;
   bscfs_pkg::rsp_type                frame;
   bscfs_pkg::rsp_type                wr_resp;

   function automatic logic [bscfs_pkg::PTR_W-1:0] next_pos(
      input logic [bscfs_pkg::PTR_W-1:0] p);
      return (p == bscfs_pkg::PTR_W'(bscfs_pkg::RING_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign chunk     = (left_ff > bscfs_pkg::COUNT_W'(bscfs_pkg::PAYLOAD_MAX))
                      ? bscfs_pkg::CHUNK_W'(bscfs_pkg::PAYLOAD_MAX)
                      : left_ff[bscfs_pkg::CHUNK_W-1:0];
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // Frame assembled from the captured payload; unused payload slots read zero.
   always_comb begin
      frame                = '0;
      frame.frame_id       = frame_id;
      frame.frame_len      = bscfs_pkg::LEN_W'(chunk) + 1'b1;
      frame.byte0          = (seq_ff == '0)
                             ? (bscfs_pkg::FIRST_MARK | 8'(total_ff))
                             : 8'(seq_ff);
      frame.last           = (left_ff == bscfs_pkg::COUNT_W'(chunk));
      for (int k = 0; k < bscfs_pkg::PAYLOAD_MAX; k++) begin
         frame.pay[k] = (bscfs_pkg::CHUNK_W'(k) < chunk) ? payload_ff[k] : 8'h00;
      end
   end

   always_comb begin
      wr_resp                = '0;
      wr_resp.write_accepted = (fill_ff < bscfs_pkg::COUNT_W'(bscfs_pkg::RING_DEPTH));
      wr_resp.last           = 1'b1;
   end

   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      rp_in        = rp_ff;
      fill_in      = fill_ff;
      total_in     = total_ff;
      left_in      = left_ff;
      seq_in       = seq_ff;
      issue_in     = issue_ff;
      pend_in      = pend_ff;
      pend_idx_in  = pend_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      cmd_pop      = 1'b0;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      cap_en       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               if (cmd.kind == bscfs_pkg::CMD_WRITE) begin
                  if (out_free) begin
                     cmd_pop      = 1'b1;
                     rsp_valid_in = 1'b1;
                     rsp_in       = wr_resp;
                     if (wr_resp.write_accepted) begin
                        wr_en   = 1'b1;
                        wp_in   = next_pos(wp_ff);
                        fill_in = fill_ff + 1'b1;
                     end
                  end
               end else if (fill_ff == '0) begin
                  // Flush of an empty ring produces no transaction.
                  cmd_pop = 1'b1;
               end else begin
                  total_in = fill_ff;
                  left_in  = fill_ff;
                  fill_in  = '0;
                  seq_in   = '0;
                  issue_in = '0;
                  pend_in  = 1'b0;
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            // Reads are issued one per cycle; read data is registered in mem_q_ff and then captured into the payload.
            pend_in = 1'b0;
            if (issue_ff < chunk) begin
               rd_en       = 1'b1;
               rp_in       = next_pos(rp_ff);
               issue_in    = issue_ff + 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = issue_ff[bscfs_pkg::PIDX_W-1:0];
            end
            if (pend_ff) begin
               cap_en = 1'b1;
               if (bscfs_pkg::CHUNK_W'(pend_idx_ff) == chunk - 1'b1) begin
                  state_in = ST_SEND;
               end
            end
         end
         ST_SEND: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = frame;
               left_in      = left_ff - bscfs_pkg::COUNT_W'(chunk);
               seq_in       = seq_ff + 1'b1;
               issue_in     = '0;
               if (frame.last) begin
                  cmd_pop  = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         rp_ff        <= '0;
         fill_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         fill_ff      <= fill_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      total_ff    <= total_in;
      left_ff     <= left_in;
      seq_ff      <= seq_in;
      issue_ff    <= issue_in;
      pend_idx_ff <= pend_idx_in;
      rsp_ff      <= rsp_in;
      if (cap_en) begin
         payload_ff[pend_idx_ff] <= mem_q_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_ff[wp_ff] <= cmd.data;
      end
      if (rd_en) begin
         mem_q_ff <= ring_ff[rp_ff];
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= bscfs_pkg::COUNT_W'(bscfs_pkg::RING_DEPTH))
      else $error("ring fill count exceeds ring depth");

   a_pop_needs_cmd: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("command popped from an empty queue");

   a_send_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEND && rsp_valid_ff && !rsp_ready) |=> (state_ff == ST_SEND))
      else $error("frame left the sequencer while the output register was full");

   a_capture_in_chunk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ && pend_ff) |-> (bscfs_pkg::CHUNK_W'(pend_idx_ff) < chunk))
      else $error("payload capture outside the current frame");

endmodule

// ----- design/byte_stream_can_frame_segmenter.sv -----
// ----------------------------------------------------------------------------
// byte_stream_can_frame_segmenter: byte stream to CAN frame segmenter
// Buffers written bytes in a transmit ring and drains it into CAN frames on
// a flush; holds the identifier configuration registers.
// ----------------------------------------------------------------------------
// A write response reaches the output register after its request passes the command
// queue. Writes sustain one transaction per cycle while the response output is not
// stalled and no flush is in progress. A flush of n bytes produces ceil(n/7) frames,
// each read from the ring byte by byte, paced by the single read port of the ring memory.
// Reset (synchronous, active high) empties the ring and the command queue and
// zeroes the configuration; ring contents are not cleared and need no pass.
module byte_stream_can_frame_segmenter (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [bscfs_pkg::REQ_TDATA_W-1:0]   req_tdata,   // [7:0] data_byte
   input  logic [0:0]                          req_tuser,   // [0] opcode
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [0] write_accepted, [29:1] frame_id, [33:30] frame_len, [41:34] byte0,
   // [49:42] byte1, [57:50] byte2, [65:58] byte3, [73:66] byte4,
   // [81:74] byte5, [89:82] byte6, [97:90] byte7, upper bits zero
   output logic [bscfs_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic                                rsp_tlast,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic                                csr_index,
   input  logic [bscfs_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   logic [bscfs_pkg::ID_W-1:0]       id_base_ff, id_base_in;
   logic [bscfs_pkg::SENDIDX_W-1:0]  send_index_ff, send_index_in;
   logic [bscfs_pkg::ID_W-1:0]       frame_id;
   logic                             cmd_valid;
   logic                             cmd_pop;
   bscfs_pkg::cmd_type               cmd;
   bscfs_pkg::rsp_type               rsp;

   assign csr_ready = 1'b1;

   always_comb begin
      id_base_in    = id_base_ff;
      send_index_in = send_index_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            bscfs_pkg::CSR_ID_BASE:    id_base_in    = csr_wdata[bscfs_pkg::ID_W-1:0];
            bscfs_pkg::CSR_SEND_INDEX: send_index_in = csr_wdata[bscfs_pkg::SENDIDX_W-1:0];
            default: begin
               id_base_in = id_base_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         id_base_ff    <= '0;
         send_index_ff <= '0;
      end else begin
         id_base_ff    <= id_base_in;
         send_index_ff <= send_index_in;
      end
   end

   assign frame_id = id_base_ff | bscfs_pkg::ID_W'(send_index_ff);

   bscfs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_data   (req_tdata[7:0]),
      .req_opcode (req_tuser[0]),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop)
   );

   bscfs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .frame_id  (frame_id),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   assign rsp_tdata = {{bscfs_pkg::RSP_PAD_W{1'b0}}, rsp.pay, rsp.byte0, rsp.frame_len,
                       rsp.frame_id, rsp.write_accepted};
   assign rsp_tlast = rsp.last;

endmodule
